>>> rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared assertion macros for the tick engine RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Antecedent in a cycle implies consequent in the same cycle.
`define ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Antecedent in a cycle implies consequent in the next cycle.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/tcswt_pkg.sv
// ----------------------------------------------------------------------------
// tcswt_pkg
// Shared types and constants of the tick engine with sleeper table.
// ----------------------------------------------------------------------------
package tcswt_pkg;

    // result kinds
    localparam logic [1:0] KIND_TICK   = 2'd0;
    localparam logic [1:0] KIND_WOKEN  = 2'd1;
    localparam logic [1:0] KIND_ACCEPT = 2'd2;
    localparam logic [1:0] KIND_REJECT = 2'd3;

    // input function codes
    localparam logic FUNC_TICK  = 1'b0;
    localparam logic FUNC_SLEEP = 1'b1;

    // register indexes
    localparam logic REG_TICKS_PER_SECOND   = 1'b0;
    localparam logic REG_TICKS_PER_SCHEDULE = 1'b1;

    localparam logic [15:0] TPS_RESET   = 16'd50;
    localparam logic [15:0] TPSCH_RESET = 16'd1;

    localparam int PID_W   = 15;
    localparam int CLK_W   = 32;
    localparam int HOURS_W = 20;
    localparam int MS_W    = 6;
    localparam int DIV_W   = 16;
    localparam int IN_DATA_W  = 48;
    localparam int OUT_DATA_W = 80;

    localparam logic [MS_W-1:0] MS_LAST = 6'd59;

    // controller -> datapath
    typedef struct packed {
        logic load;         // capture the input word
        logic tick;         // advance clock, time of day and dividers
        logic scan_clr;     // restart the scan at slot 0
        logic scan_adv;     // step to the next slot
        logic emit_sleep;   // emit accept / reject, fill a slot
        logic emit_wake;    // emit woken result, free current slot
        logic emit_status;  // emit tick status
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic sch_fire;     // this tick reaches the schedule point
        logic hit;          // current slot is due
        logic scan_last;    // current slot is the last one
        logic out_free;     // output register can take a word
    } t_sts;

    // decoded register write
    typedef struct packed {
        logic            we;
        logic            sel;
        logic [DIV_W-1:0] data;
    } t_cfg_wr;

endpackage

>>> rtl/tcswt_ctrl.sv
// ----------------------------------------------------------------------------
// tcswt_ctrl
// Sequencer: accepts one word, runs tick update, table scan and emits.
// ----------------------------------------------------------------------------
module tcswt_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  logic             i_in_func,
    output logic             o_in_ready,
    input  tcswt_pkg::t_sts  i_sts,
    output tcswt_pkg::t_cmd  o_cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_TICK,
        ST_SCAN,
        ST_STATUS,
        ST_SLEEP
    } t_state;

    t_state r_state;
    t_state n_state;

    assign o_in_ready = (r_state == ST_IDLE);

    always_comb begin
        o_cmd   = '0;
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state = (i_in_func == tcswt_pkg::FUNC_SLEEP) ? ST_SLEEP : ST_TICK;
                end
            end
            ST_TICK: begin
                o_cmd.tick     = 1'b1;
                o_cmd.scan_clr = 1'b1;
                n_state = i_sts.sch_fire ? ST_SCAN : ST_STATUS;
            end
            ST_SCAN: begin
                // hold on a due slot until the output can take it
                if (!i_sts.hit || i_sts.out_free) begin
                    o_cmd.emit_wake = i_sts.hit;
                    o_cmd.scan_adv  = 1'b1;
                    if (i_sts.scan_last) begin
                        n_state = ST_STATUS;
                    end
                end
            end
            ST_STATUS: begin
                if (i_sts.out_free) begin
                    o_cmd.emit_status = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            ST_SLEEP: begin
                if (i_sts.out_free) begin
                    o_cmd.emit_sleep = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

>>> rtl/tcswt_dp.sv
// ----------------------------------------------------------------------------
// tcswt_dp
// Datapath: registers, clock and time of day, sleeper table, output word.
// ----------------------------------------------------------------------------
module tcswt_dp #(
    parameter int TABLE_SLOTS = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  tcswt_pkg::t_cmd                     i_cmd,
    output tcswt_pkg::t_sts                     o_sts,
    input  tcswt_pkg::t_cfg_wr                  i_cfg,
    output logic [tcswt_pkg::DIV_W-1:0]         o_tps,
    output logic [tcswt_pkg::DIV_W-1:0]         o_tpsch,
    input  logic [tcswt_pkg::IN_DATA_W-1:0]     i_in_data,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic [1:0]                          o_out_kind,
    output logic [tcswt_pkg::OUT_DATA_W-1:0]    o_out_data,
    output logic                                o_out_last
);

    localparam int SLOT_W = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
    localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(TABLE_SLOTS - 1);

    // configuration and tick state
    logic [tcswt_pkg::DIV_W-1:0]   r_tps;
    logic [tcswt_pkg::DIV_W-1:0]   r_tpsch;
    logic [tcswt_pkg::DIV_W-1:0]   r_sec_div;
    logic [tcswt_pkg::DIV_W-1:0]   r_sch_div;
    logic [tcswt_pkg::CLK_W-1:0]   r_tick;
    logic [tcswt_pkg::HOURS_W-1:0] r_hours;
    logic [tcswt_pkg::MS_W-1:0]    r_minutes;
    logic [tcswt_pkg::MS_W-1:0]    r_seconds;

    // sleeper table
    logic [TABLE_SLOTS-1:0]          r_busy;
    logic [tcswt_pkg::PID_W-1:0]     mem_pid  [TABLE_SLOTS];
    logic [tcswt_pkg::CLK_W-1:0]     mem_wake [TABLE_SLOTS];
    logic [tcswt_pkg::PID_W-1:0]     r_rd_pid;
    logic [tcswt_pkg::CLK_W-1:0]     r_rd_wake;
    logic [SLOT_W-1:0]               r_idx;
    logic [SLOT_W-1:0]               rd_addr;
    logic [SLOT_W-1:0]               free_idx;
    logic                            any_free;
    logic                            sleep_wr;

    // captured input
    logic [tcswt_pkg::PID_W-1:0]     r_in_pid;
    logic [tcswt_pkg::CLK_W-1:0]     r_in_wake;

    // output word
    logic                            r_ov;
    logic [1:0]                      r_okind;
    logic [tcswt_pkg::PID_W-1:0]     r_opid;
    logic [tcswt_pkg::CLK_W-1:0]     r_oclk;
    logic [tcswt_pkg::HOURS_W-1:0]   r_ohours;
    logic [tcswt_pkg::MS_W-1:0]      r_omin;
    logic [tcswt_pkg::MS_W-1:0]      r_osec;
    logic                            r_olast;

    logic [tcswt_pkg::DIV_W-1:0]     sec_inc;
    logic [tcswt_pkg::DIV_W-1:0]     sch_inc;
    logic                            sec_fire;
    logic                            scan_last;
    logic                            out_free;
    logic                            emit;

    assign sec_inc   = r_sec_div + 1'b1;
    assign sch_inc   = r_sch_div + 1'b1;
    assign sec_fire  = (sec_inc >= r_tps);
    assign scan_last = (r_idx == SLOT_LAST);
    assign out_free  = !r_ov || i_out_ready;
    assign emit      = i_cmd.emit_sleep || i_cmd.emit_wake || i_cmd.emit_status;
    assign sleep_wr  = i_cmd.emit_sleep && any_free;

    assign o_sts.sch_fire  = (sch_inc >= r_tpsch);
    assign o_sts.hit       = r_busy[r_idx] && (r_tick >= r_rd_wake);
    assign o_sts.scan_last = scan_last;
    assign o_sts.out_free  = out_free;

    assign o_tps   = r_tps;
    assign o_tpsch = r_tpsch;

    // first free slot, lowest index wins
    always_comb begin
        free_idx = '0;
        any_free = 1'b0;
        for (int i = TABLE_SLOTS - 1; i >= 0; i--) begin
            if (!r_busy[i]) begin
                free_idx = SLOT_W'(i);
                any_free = 1'b1;
            end
        end
    end

    // read address runs one slot ahead of the registered read data
    always_comb begin
        priority if (i_cmd.scan_clr) begin
            rd_addr = '0;
        end else if (i_cmd.scan_adv && !scan_last) begin
            rd_addr = r_idx + 1'b1;
        end else begin
            rd_addr = r_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (sleep_wr) begin
            mem_pid[free_idx]  <= r_in_pid;
            mem_wake[free_idx] <= r_in_wake;
        end
        r_rd_pid  <= mem_pid[rd_addr];
        r_rd_wake <= mem_wake[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_in_pid  <= i_in_data[tcswt_pkg::PID_W-1:0];
            r_in_wake <= i_in_data[tcswt_pkg::PID_W +: tcswt_pkg::CLK_W];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tps     <= tcswt_pkg::TPS_RESET;
            r_tpsch   <= tcswt_pkg::TPSCH_RESET;
            r_sec_div <= '0;
            r_sch_div <= '0;
            r_tick    <= '0;
            r_hours   <= '0;
            r_minutes <= '0;
            r_seconds <= '0;
            r_busy    <= '0;
            r_idx     <= '0;
        end else begin
            if (i_cfg.we) begin
                if (i_cfg.sel == tcswt_pkg::REG_TICKS_PER_SECOND) begin
                    r_tps <= i_cfg.data;
                end else begin
                    r_tpsch <= i_cfg.data;
                end
                r_sec_div <= '0;
                r_sch_div <= '0;
            end else if (i_cmd.tick) begin
                r_tick    <= r_tick + 1'b1;
                r_sec_div <= sec_fire ? '0 : sec_inc;
                r_sch_div <= o_sts.sch_fire ? '0 : sch_inc;
                if (sec_fire) begin
                    if (r_seconds == tcswt_pkg::MS_LAST) begin
                        r_seconds <= '0;
                        if (r_minutes == tcswt_pkg::MS_LAST) begin
                            r_minutes <= '0;
                            r_hours   <= r_hours + 1'b1;
                        end else begin
                            r_minutes <= r_minutes + 1'b1;
                        end
                    end else begin
                        r_seconds <= r_seconds + 1'b1;
                    end
                end
            end
            if (i_cmd.scan_clr) begin
                r_idx <= '0;
            end else if (i_cmd.scan_adv && !scan_last) begin
                r_idx <= r_idx + 1'b1;
            end
            if (i_cmd.emit_wake) begin
                r_busy[r_idx] <= 1'b0;
            end
            if (sleep_wr) begin
                r_busy[free_idx] <= 1'b1;
            end
        end
    end

    // output register, control part
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (emit) begin
            r_ov <= 1'b1;
        end else if (i_out_ready) begin
            r_ov <= 1'b0;
        end
    end

    // output register, payload part
    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_oclk   <= r_tick;
            r_ohours <= r_hours;
            r_omin   <= r_minutes;
            r_osec   <= r_seconds;
            r_olast  <= !i_cmd.emit_wake;
            if (i_cmd.emit_wake) begin
                r_okind <= tcswt_pkg::KIND_WOKEN;
                r_opid  <= r_rd_pid;
            end else if (i_cmd.emit_sleep && any_free) begin
                r_okind <= tcswt_pkg::KIND_ACCEPT;
                r_opid  <= r_in_pid;
            end else if (i_cmd.emit_sleep) begin
                r_okind <= tcswt_pkg::KIND_REJECT;
                r_opid  <= '0;
            end else begin
                r_okind <= tcswt_pkg::KIND_TICK;
                r_opid  <= '0;
            end
        end
    end

    assign o_out_valid = r_ov;
    assign o_out_kind  = r_okind;
    assign o_out_last  = r_olast;
    assign o_out_data  = {1'b0, r_osec, r_omin, r_ohours, r_oclk, r_opid};

endmodule

>>> rtl/tick_clock_sleep_wakeup_table_top.sv
// ----------------------------------------------------------------------------
// tick_clock_sleep_wakeup_table_top
// Timer tick engine: tick count, time of day and a sleeper wake-up table.
// ----------------------------------------------------------------------------
//
//  Port group   Dir  Role
//  s_axis_*     in   one word per item: tick or sleep request
//  m_axis_*     out  result words: wake-ups, sleep answer, tick status
//  APB          in   two divider registers at 0x0 and 0x4
//
//  A sleep request is loaded in the idle state and answered from the sleep state
//  once the output is free. A tick passes the tick and status states; a tick that
//  reaches the schedule point walks the slot memory in between, one table slot
//  (TABLE_SLOTS) per cycle while no due slot waits on the output, set by its single read port.
//  One item is in flight at a time; the next word is taken once the last
//  result of the current one sits in the output register.
//  Reset is synchronous, active low, and leaves the table empty.
//
`include "assert_macros.svh"

module tick_clock_sleep_wakeup_table_top #(
    parameter int TABLE_SLOTS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,   // [14:0] pid, [46:15] wake_time, [47] zero
    input  logic [0:0]  s_axis_tuser,   // [0] func
    // result stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [79:0] m_axis_tdata,   // [14:0] woken_pid, [46:15] clock_res,
                                        // [66:47] hours, [72:67] minutes,
                                        // [78:73] seconds, [79] zero
    output logic [1:0]  m_axis_tuser,   // [1:0] kind
    output logic        m_axis_tlast,
    // register port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    tcswt_pkg::t_cmd    cmd;
    tcswt_pkg::t_sts    sts;
    tcswt_pkg::t_cfg_wr cfg;
    logic [tcswt_pkg::DIV_W-1:0] tps;
    logic [tcswt_pkg::DIV_W-1:0] tpsch;

    // zero-wait register port; word address picks the register
    assign pready   = 1'b1;
    assign cfg.we   = psel && penable && pwrite && pready;
    assign cfg.sel  = paddr[2];
    assign cfg.data = pwdata[tcswt_pkg::DIV_W-1:0];

    always_comb begin
        unique case (paddr[2])
            tcswt_pkg::REG_TICKS_PER_SECOND:   prdata = {16'b0, tps};
            tcswt_pkg::REG_TICKS_PER_SCHEDULE: prdata = {16'b0, tpsch};
            default:                           prdata = '0;
        endcase
    end

    // sequencer: one item at a time
    tcswt_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .i_in_func  (s_axis_tuser[0]),
        .o_in_ready (s_axis_tready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    // counters, sleeper table and output register
    tcswt_dp #(
        .TABLE_SLOTS (TABLE_SLOTS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_cfg       (cfg),
        .o_tps       (tps),
        .o_tpsch     (tpsch),
        .i_in_data   (s_axis_tdata),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_out_kind  (m_axis_tuser),
        .o_out_data  (m_axis_tdata),
        .o_out_last  (m_axis_tlast)
    );

    // an accepted word closes the input in the next cycle
    `ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, s_axis_tvalid && s_axis_tready, !s_axis_tready, "input accepted while previous item still in work")

    // only wake-ups may be followed by further results of the same item
    `ASSERT_SAME(a_nonlast_is_wake, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tlast, m_axis_tuser == tcswt_pkg::KIND_WOKEN, "non-final result is not a wake-up")

    // status and reject words carry no pid
    `ASSERT_SAME(a_no_pid, i_clk, i_rst_n, m_axis_tvalid && (m_axis_tuser == tcswt_pkg::KIND_TICK || m_axis_tuser == tcswt_pkg::KIND_REJECT), m_axis_tlast && (m_axis_tdata[14:0] == 15'd0), "status or reject word malformed")

endmodule

>>> tb/tb_tick_clock_sleep_wakeup_table_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_tick_clock_sleep_wakeup_table_top
// Self-checking bench for the timer tick engine with its sleeper table.
// ----------------------------------------------------------------------------
// A short scripted run covers reset values, pid and wake-time extremes,
// repeated pids, an overdue sleeper and a full table. Randomized phases
// follow, each one under a different pair of divider settings. Every input
// word accepted on the stream goes through a behavioral copy of the engine,
// and the words it forecasts are matched in order against the output stream.
// Both stream sides idle at random.
// ----------------------------------------------------------------------------

module tb_tick_clock_sleep_wakeup_table_top;

    import tcswt_pkg::*;

    localparam int SLOTS = 16;

    // One output word, split into its fields.
    typedef struct packed {
        logic [1:0]         kind;
        logic [PID_W-1:0]   pid;
        logic [CLK_W-1:0]   clk_now;
        logic [HOURS_W-1:0] hrs;
        logic [MS_W-1:0]    mins;
        logic [MS_W-1:0]    secs;
        logic               last;
    } tick_word_t;

    // One row of the scripted run; reps repeats the row with pid counting up.
    typedef struct packed {
        logic             func;
        logic [PID_W-1:0] pid;
        logic [CLK_W-1:0] wake;
        int               reps;
        bit               typed;
        tick_word_t       answer;
    } stim_row_t;

    // One randomized phase: divider settings, item count, share of sleeps.
    typedef struct packed {
        logic [DIV_W-1:0] tps;
        logic [DIV_W-1:0] tpsch;
        int               items;
        int               sleep_pct;
    } phase_t;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [47:0] s_axis_tdata = '0;   // [14:0] pid, [46:15] wake_time, [47] zero
    logic [0:0]  s_axis_tuser = '0;   // [0] func
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [79:0] m_axis_tdata;        // [14:0] woken_pid, [46:15] clock_res,
                                      // [66:47] hours, [72:67] minutes,
                                      // [78:73] seconds, [79] zero
    logic [1:0]  m_axis_tuser;        // [1:0] kind
    logic        m_axis_tlast;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    tick_clock_sleep_wakeup_table_top #(
        .TABLE_SLOTS(SLOTS)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always #1 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Engine copy: divider registers, counters and the sleeper table
    // ------------------------------------------------------------------
    logic [DIV_W-1:0]   tps_reg = TPS_RESET;
    logic [DIV_W-1:0]   tpsch_reg = TPSCH_RESET;
    logic [CLK_W-1:0]   ticks = '0;
    logic [DIV_W-1:0]   sec_div = '0;
    logic [DIV_W-1:0]   sched_div = '0;
    logic [HOURS_W-1:0] hrs = '0;
    logic [MS_W-1:0]    mins = '0;
    logic [MS_W-1:0]    secs = '0;
    logic               slot_busy [SLOTS];
    logic [PID_W-1:0]   slot_pid  [SLOTS];
    logic [CLK_W-1:0]   slot_wake [SLOTS];

    tick_word_t fresh_words [$];    // words forecast for the item just taken
    tick_word_t pending_words [$];  // words still owed by the engine
    int         errors = 0;

    initial begin
        foreach (slot_busy[i]) slot_busy[i] = 1'b0;
    end

    // Build a word from the counters as they stand now.
    function automatic tick_word_t make_word(logic [1:0] kind, logic [PID_W-1:0] pid,
                                             logic last);
        tick_word_t w;
        w.kind    = kind;
        w.pid     = pid;
        w.clk_now = ticks;
        w.hrs     = hrs;
        w.mins    = mins;
        w.secs    = secs;
        w.last    = last;
        return w;
    endfunction

    // Forecast the words of one item and advance the engine copy.
    task automatic forecast_words(input logic func, input logic [PID_W-1:0] pid,
                                  input logic [CLK_W-1:0] wake);
        int free_slot;
        int i;
        fresh_words.delete();
        if (func == FUNC_SLEEP) begin
            free_slot = -1;
            for (i = 0; i < SLOTS; i++) begin
                if (!slot_busy[i] && free_slot < 0) free_slot = i;
            end
            if (free_slot < 0) begin
                fresh_words.push_back(make_word(KIND_REJECT, '0, 1'b1));
            end else begin
                slot_busy[free_slot] = 1'b1;
                slot_pid[free_slot]  = pid;
                slot_wake[free_slot] = wake;
                fresh_words.push_back(make_word(KIND_ACCEPT, pid, 1'b1));
            end
        end else begin
            ticks   = ticks + 1'b1;
            sec_div = sec_div + 1'b1;
            // a zero setting fires on every tick, which the compare gives as is
            if (sec_div >= tps_reg) begin
                sec_div = '0;
                if (secs == MS_LAST) begin
                    secs = '0;
                    if (mins == MS_LAST) begin
                        mins = '0;
                        hrs  = hrs + 1'b1;
                    end else begin
                        mins = mins + 1'b1;
                    end
                end else begin
                    secs = secs + 1'b1;
                end
            end
            sched_div = sched_div + 1'b1;
            if (sched_div >= tpsch_reg) begin
                sched_div = '0;
                for (i = 0; i < SLOTS; i++) begin
                    if (slot_busy[i] && ticks >= slot_wake[i]) begin
                        slot_busy[i] = 1'b0;
                        fresh_words.push_back(make_word(KIND_WOKEN, slot_pid[i], 1'b0));
                    end
                end
            end
            fresh_words.push_back(make_word(KIND_TICK, '0, 1'b1));
        end
    endtask

    // Often back to back, otherwise a short pause, rarely a long one.
    function automatic int pick_gap(bit calm);
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 45) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    // ------------------------------------------------------------------
    // Input side
    // ------------------------------------------------------------------
    bit tx_calm = 1'b0;

    // Offer one word, hold it until taken, then log what it should cause.
    // A typed row replaces the forecast with its own answer.
    task automatic send_word(input logic func, input logic [PID_W-1:0] pid,
                             input logic [CLK_W-1:0] wake, input bit typed,
                             input tick_word_t answer);
        int gap;
        gap = pick_gap(tx_calm);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {1'b0, wake, pid};
        s_axis_tuser  <= func;
        do @(posedge i_clk); while (!s_axis_tready);
        forecast_words(func, pid, wake);
        if (typed) pending_words.push_back(answer);
        else foreach (fresh_words[k]) pending_words.push_back(fresh_words[k]);
    endtask

    // Drop valid and hold until every owed word has come out.
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (pending_words.size() != 0);
    endtask

    // One APB transfer: setup cycle, then access until pready.
    task automatic apb_xfer(input bit wr, input logic idx, input logic [31:0] wdata,
                            output logic [31:0] rdata);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= {idx, 2'b00};
        pwdata  <= wdata;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        rdata = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Write a divider (junk in the upper half), restart both dividers, read back.
    task automatic set_divider(input logic idx, input logic [DIV_W-1:0] val);
        logic [31:0] rd;
        apb_xfer(1'b1, idx, {16'($urandom), val}, rd);
        if (idx == REG_TICKS_PER_SECOND) tps_reg = val;
        else tpsch_reg = val;
        sec_div   = '0;
        sched_div = '0;
        apb_xfer(1'b0, idx, '0, rd);
        if (rd[DIV_W-1:0] !== val) begin
            $display("%0t: register %0d read back: expected %0d, actual %0d",
                     $time, idx, val, rd[DIV_W-1:0]);
            errors++;
        end
    endtask

    // ------------------------------------------------------------------
    // Output side: random stalls, and the in-order check of every word
    // ------------------------------------------------------------------
    int rx_stall = 0;
    int rx_cycles = 0;
    bit rx_calm = 1'b0;

    task automatic diff_field(input string name, input longint unsigned want,
                              input longint unsigned got);
        if (want !== got) begin
            $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
            errors++;
        end
    endtask

    task automatic check_word();
        tick_word_t got;
        tick_word_t want;
        got.kind    = m_axis_tuser;
        got.pid     = m_axis_tdata[14:0];
        got.clk_now = m_axis_tdata[46:15];
        got.hrs     = m_axis_tdata[66:47];
        got.mins    = m_axis_tdata[72:67];
        got.secs    = m_axis_tdata[78:73];
        got.last    = m_axis_tlast;
        if (pending_words.size() == 0) begin
            $display("%0t: unexpected word: kind %0d pid %0d clock %0d",
                     $time, got.kind, got.pid, got.clk_now);
            errors++;
        end else begin
            want = pending_words.pop_front();
            diff_field("kind", want.kind, got.kind);
            diff_field("woken_pid", want.pid, got.pid);
            diff_field("clock_res", want.clk_now, got.clk_now);
            diff_field("hours", want.hrs, got.hrs);
            diff_field("minutes", want.mins, got.mins);
            diff_field("seconds", want.secs, got.secs);
            diff_field("last", want.last, got.last);
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) check_word();
        // every so often switch stalls off for a stretch
        rx_cycles++;
        if (rx_cycles % 64 == 0) rx_calm = ($urandom_range(0, 3) == 0);
        if (rx_stall != 0) begin
            rx_stall--;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
            rx_stall = pick_gap(rx_calm);
        end
    end

    // ------------------------------------------------------------------
    // Scripted run under the reset settings (50 ticks a second, scan on
    // every tick). Rows with an answer are single words that can be read
    // off directly; the others go through the forecast. The slot taken by
    // the all-ones wake time never comes due and stays busy for good.
    // A tick count or hours wrap would take billions of ticks and is not
    // reached here.
    // ------------------------------------------------------------------
    localparam int SCRIPT_ROWS = 10;
    stim_row_t script [SCRIPT_ROWS] = '{
        // first tick after reset: status only, clock 1, time of day zero
        '{FUNC_TICK, 15'd0, 32'd0, 1, 1'b1,
          '{KIND_TICK, 15'd0, 32'd1, 20'd0, 6'd0, 6'd0, 1'b1}},
        // highest pid with a wake time that never comes
        '{FUNC_SLEEP, 15'h7FFF, 32'hFFFF_FFFF, 1, 1'b1,
          '{KIND_ACCEPT, 15'h7FFF, 32'd1, 20'd0, 6'd0, 6'd0, 1'b1}},
        // pid zero, already overdue: woken at the next scan
        '{FUNC_SLEEP, 15'd0, 32'd0, 1, 1'b1,
          '{KIND_ACCEPT, 15'd0, 32'd1, 20'd0, 6'd0, 6'd0, 1'b1}},
        '{FUNC_TICK, 15'd0, 32'd0, 1, 1'b0, '0},
        // same pid twice: two slots
        '{FUNC_SLEEP, 15'd5, 32'd4, 1, 1'b0, '0},
        '{FUNC_SLEEP, 15'd5, 32'd4, 1, 1'b0, '0},
        // ticks carrying all-ones in the unused fields
        '{FUNC_TICK, 15'h7FFF, 32'hFFFF_FFFF, 2, 1'b0, '0},
        // fill every remaining slot
        '{FUNC_SLEEP, 15'h2AAA, 32'd6, 15, 1'b0, '0},
        // table full: rejected, pid zero
        '{FUNC_SLEEP, 15'h1234, 32'h5555_5555, 1, 1'b1,
          '{KIND_REJECT, 15'd0, 32'd4, 20'd0, 6'd0, 6'd0, 1'b1}},
        // second tick wakes fifteen sleepers at once
        '{FUNC_TICK, 15'd0, 32'd0, 2, 1'b0, '0}
    };

    // Randomized phases: moderate, fastest, frozen (no scans, table fills
    // and rejects), zero settings (fire on every tick), then moderate again.
    localparam int PHASES = 5;
    phase_t phases [PHASES] = '{
        '{16'd3,     16'd2,     70, 50},
        '{16'd1,     16'd1,     90, 45},
        '{16'd65535, 16'd65535, 40, 70},
        '{16'd0,     16'd0,     90, 45},
        '{16'd7,     16'd3,     80, 50}
    };

    initial begin
        logic [PID_W-1:0] pid;
        logic [CLK_W-1:0] wake;
        int               n;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (script[r]) begin
            for (int k = 0; k < script[r].reps; k++) begin
                send_word(script[r].func, script[r].pid + PID_W'(k), script[r].wake,
                          script[r].typed, script[r].answer);
            end
        end

        foreach (phases[p]) begin
            // settings change only with nothing in flight
            drain();
            if ($urandom_range(0, 1) == 0) begin
                set_divider(REG_TICKS_PER_SECOND, phases[p].tps);
                set_divider(REG_TICKS_PER_SCHEDULE, phases[p].tpsch);
            end else begin
                set_divider(REG_TICKS_PER_SCHEDULE, phases[p].tpsch);
                set_divider(REG_TICKS_PER_SECOND, phases[p].tps);
            end
            for (n = 0; n < phases[p].items; n++) begin
                if (n % 32 == 0) tx_calm = ($urandom_range(0, 3) == 0);
                // now and then hold off until the output side has caught up
                if ($urandom_range(0, 29) == 0) drain();
                if ($urandom_range(0, 99) < phases[p].sleep_pct) begin
                    pid = PID_W'($urandom_range(0, 32767));
                    // mostly due soon, some already overdue
                    if ($urandom_range(0, 9) < 7) wake = ticks + $urandom_range(0, 12);
                    else wake = $urandom_range(0, ticks);
                    send_word(FUNC_SLEEP, pid, wake, 1'b0, '0);
                end else begin
                    send_word(FUNC_TICK, PID_W'($urandom_range(0, 32767)), $urandom,
                              1'b0, '0);
                end
            end
        end

        drain();
        // leave room for a stray word behind the last one
        repeat (40) @(posedge i_clk);
        if (errors == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest legal run.
    initial begin
        #2_000_000;
        $display("== FAIL ==");
        $finish;
    end

endmodule
